// ===== rtl/vlac_pkg.sv =====
// Types and constants shared by the valve leak alarm controller files.
package vlac_pkg;

  localparam int unsigned CodeW = 24;
  localparam int unsigned CfgW  = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_INITIAL_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAIR_NIBBLE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEAK_NIBBLE  = 2'd2;

  localparam logic [3:0] PAIR_NIBBLE_RESET = 4'd0;
  localparam logic [3:0] LEAK_NIBBLE_RESET = 4'd1;

  localparam logic [3:0] ACT_START      = 4'd0;
  localparam logic [3:0] ACT_WIFI       = 4'd1;
  localparam logic [3:0] ACT_RF433      = 4'd2;
  localparam logic [3:0] ACT_SHORT_KEY  = 4'd3;
  localparam logic [3:0] ACT_LONG_KEY   = 4'd4;
  localparam logic [3:0] ACT_CUTOFF     = 4'd5;
  localparam logic [3:0] ACT_ARRIVED    = 4'd6;
  localparam logic [3:0] ACT_JAMMED     = 4'd7;
  localparam logic [3:0] ACT_PAIR_TOUT  = 4'd8;
  localparam logic [3:0] ACT_TRAVEL_TOUT = 4'd9;

  localparam logic [7:0] WIFI_OPEN  = 8'h01;
  localparam logic [7:0] WIFI_CLOSE = 8'h02;
  localparam logic [7:0] WIFI_RESET = 8'hFF;

  localparam logic [1:0] MOTOR_STATUS_CLOSED = 2'd3;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_RUN   = 3'd1;
  localparam logic [2:0] MODE_MOTOR = 3'd2;
  localparam logic [2:0] MODE_PAIR  = 3'd3;
  localparam logic [2:0] MODE_ERR   = 3'd4;

  localparam logic [1:0] MC_NONE  = 2'd0;
  localparam logic [1:0] MC_OPEN  = 2'd1;
  localparam logic [1:0] MC_CLOSE = 2'd2;
  localparam logic [1:0] MC_STOP  = 2'd3;

  localparam logic [1:0] LED_NONE  = 2'd0;
  localparam logic [1:0] LED_ON    = 2'd1;
  localparam logic [1:0] LED_OFF   = 2'd2;
  localparam logic [1:0] LED_BLINK = 2'd3;

  localparam logic [15:0] PERIOD_STOP = 16'd5000;
  localparam logic [15:0] PERIOD_PAIR = 16'd2000;
  localparam logic [15:0] PERIOD_JAM  = 16'hFFFF;
  localparam logic [15:0] ON_SHORT    = 16'd50;
  localparam logic [15:0] ON_LONG     = 16'd500;
  localparam logic [15:0] ON_MID      = 16'd100;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] wifi_command;
    logic [7:0] rf_first_byte;
    logic [7:0] rf_second_byte;
    logic [7:0] rf_third_byte;
    logic [1:0] motor_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       control_state;
    logic [1:0]       motor_command;
    logic [1:0]       led1_command;
    logic [15:0]      led1_period;
    logic [15:0]      led1_on_time;
    logic [1:0]       led2_command;
    logic [15:0]      led2_period;
    logic [15:0]      led2_on_time;
    logic             store_code_strobe;
    logic [CodeW-1:0] code_to_store;
  } out_item_t;

endpackage

// ===== rtl/vlac_if.sv =====
// Valid/ready channel interfaces for event beats and result beats.
interface vlac_in_if;
  import vlac_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vlac_out_if;
  import vlac_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/valve_leak_alarm_controller_core.sv =====
// Leak-alarm valve controller: event decode, mode machine and result register.
//
//   channel   dir  beat contents
//   in_if     in   action, WiFi byte, 433 MHz frame bytes, motor status
//   out_if    out  mode, motor and LED commands, code store strobe and code
//   cfg_*     in   register writes (initial code, pair and leak nibbles)
//
// One beat per cycle unless a held result stalls; its result appears next cycle.
// The mode and paired code update at the edge that accepts the event.
// A held result still accepts a new event in the cycle it is taken.
// Reset returns the mode to idle and clears the code and the result register valid.
module valve_leak_alarm_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vlac_in_if.sink                       in_if,
  vlac_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [vlac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vlac_pkg::CfgW-1:0]     cfg_wdata_i
);
  import vlac_pkg::*;

  typedef enum logic [3:0] {
    EVT_NONE, EVT_START, EVT_W_OPEN, EVT_W_CLOSE, EVT_W_RESET, EVT_LEAK,
    EVT_PAIRED, EVT_SHORT, EVT_LONG, EVT_CUT, EVT_ARRIVE, EVT_TRAVEL_TO,
    EVT_PAIR_TO
  } evt_e;

  logic [CodeW-1:0] init_code_q;
  logic [3:0]       pair_nib_q;
  logic [3:0]       leak_nib_q;
  logic [2:0]       mode_q, mode_d;
  logic [CodeW-1:0] code_q, code_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q;
  out_item_t        res;
  evt_e             evt;
  logic             in_fire;
  logic             leak_match;
  in_item_t         it;

  assign it        = in_if.data;
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire   = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_code_q <= '0;
      pair_nib_q  <= PAIR_NIBBLE_RESET;
      leak_nib_q  <= LEAK_NIBBLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INITIAL_CODE: init_code_q <= cfg_wdata_i[CodeW-1:0];
        CFG_PAIR_NIBBLE:  pair_nib_q  <= cfg_wdata_i[3:0];
        CFG_LEAK_NIBBLE:  leak_nib_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign leak_match = (it.rf_first_byte == code_q[23:16]) &&
                      (it.rf_second_byte == code_q[15:8]) &&
                      (it.rf_third_byte[7:4] == code_q[7:4]) &&
                      (it.rf_third_byte[3:0] == leak_nib_q);

  always_comb begin
    evt    = EVT_NONE;
    res    = '0;
    mode_d = mode_q;
    code_d = code_q;

    unique case (it.action)
      ACT_START: evt = EVT_START;
      ACT_WIFI: begin
        res.led1_command = LED_ON;
        priority if (it.wifi_command == WIFI_OPEN) evt = EVT_W_OPEN;
        else if (it.wifi_command == WIFI_CLOSE) evt = EVT_W_CLOSE;
        else if (it.wifi_command == WIFI_RESET) evt = EVT_W_RESET;
        else evt = EVT_NONE;
      end
      ACT_RF433: begin
        if (mode_q == MODE_PAIR) begin
          if (it.rf_third_byte[3:0] == pair_nib_q) evt = EVT_PAIRED;
        end else if (leak_match) begin
          evt = EVT_LEAK;
        end
      end
      ACT_SHORT_KEY: evt = EVT_SHORT;
      ACT_LONG_KEY:  evt = EVT_LONG;
      ACT_CUTOFF:    evt = EVT_CUT;
      ACT_ARRIVED:   evt = EVT_ARRIVE;
      ACT_JAMMED: begin
        res.led1_command = LED_BLINK;
        res.led1_period  = PERIOD_JAM;
        res.led1_on_time = ON_MID;
        evt = EVT_TRAVEL_TO;
      end
      ACT_PAIR_TOUT:   evt = EVT_PAIR_TO;
      ACT_TRAVEL_TOUT: evt = EVT_TRAVEL_TO;
      default: evt = EVT_NONE;
    endcase

    unique case (mode_q)
      MODE_IDLE: begin
        if (evt == EVT_START) begin
          mode_d = MODE_RUN;
          code_d = init_code_q;
          res.led1_command = LED_OFF;
          res.led2_command = LED_OFF;
          res.motor_command = MC_STOP;
        end
      end
      MODE_RUN: begin
        priority if (evt == EVT_W_OPEN) begin
          mode_d = MODE_MOTOR;
          res.motor_command = MC_OPEN;
          res.led1_command = LED_ON;
        end else if (evt == EVT_W_CLOSE || evt == EVT_LEAK || evt == EVT_CUT) begin
          mode_d = MODE_MOTOR;
          res.motor_command = MC_CLOSE;
          res.led1_command = LED_ON;
        end else if (evt == EVT_SHORT) begin
          mode_d = MODE_MOTOR;
          res.motor_command = (it.motor_status == MOTOR_STATUS_CLOSED) ? MC_OPEN : MC_CLOSE;
          res.led1_command = LED_ON;
        end else if (evt == EVT_LONG) begin
          mode_d = MODE_PAIR;
          res.led1_command = LED_OFF;
          res.led2_command = LED_BLINK;
          res.led2_period  = PERIOD_PAIR;
          res.led2_on_time = ON_SHORT;
        end else begin
          mode_d = mode_q;
        end
      end
      MODE_MOTOR: begin
        priority if (evt == EVT_ARRIVE || evt == EVT_TRAVEL_TO) begin
          mode_d = (evt == EVT_ARRIVE) ? MODE_RUN : MODE_ERR;
          res.motor_command = MC_STOP;
          res.led1_command = LED_BLINK;
          res.led1_period  = PERIOD_STOP;
          res.led1_on_time = ON_SHORT;
        end else if (evt == EVT_CUT || evt == EVT_LEAK) begin
          res.motor_command = MC_CLOSE;
          res.led1_command = LED_ON;
          res.led1_period  = '0;
          res.led1_on_time = '0;
        end else begin
          mode_d = mode_q;
        end
      end
      MODE_PAIR: begin
        priority if (evt == EVT_PAIR_TO) begin
          mode_d = MODE_RUN;
          res.led1_command = LED_OFF;
          res.led2_command = LED_BLINK;
          res.led2_period  = PERIOD_PAIR;
          res.led2_on_time = ON_LONG;
        end else if (evt == EVT_PAIRED) begin
          mode_d = MODE_RUN;
          code_d = {it.rf_first_byte, it.rf_second_byte, it.rf_third_byte};
          res.store_code_strobe = 1'b1;
          res.code_to_store = {it.rf_first_byte, it.rf_second_byte, it.rf_third_byte};
          res.led2_command = LED_BLINK;
          res.led2_period  = PERIOD_STOP;
          res.led2_on_time = ON_MID;
        end else begin
          mode_d = mode_q;
        end
      end
      MODE_ERR: begin
        if (evt == EVT_SHORT || evt == EVT_W_RESET) begin
          mode_d = MODE_RUN;
          res.led1_command = LED_OFF;
          res.led1_period  = '0;
          res.led1_on_time = '0;
          res.led2_command = LED_BLINK;
          res.led2_period  = PERIOD_STOP;
          res.led2_on_time = ON_SHORT;
        end
      end
      default: mode_d = mode_q;
    endcase

    res.control_state = mode_d;
  end

  assign out_valid_d = in_fire || (out_valid_q && !out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        mode_q <= mode_d;
        code_q <= code_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted event beat produced no result beat");

  a_code_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(code_q) && $stable(mode_q))
    else $error("mode or paired code changed without an event beat");

  a_strobe_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.store_code_strobe) |->
      (out_data_q.control_state == MODE_RUN && out_data_q.code_to_store == code_q))
    else $error("code store strobe without a return to running");

  a_led1_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.led1_period != '0) |->
      (out_data_q.led1_command == LED_BLINK))
    else $error("LED1 timing given without a blink command");
`endif

endmodule
